// ----- design/pss_pkg.sv -----
package pss_pkg;

    // Default coordinate width; the fraction point does not enter the arithmetic
    localparam int COORD_BITS_DEF = 16;

    // Control that travels with each request down the pipeline
    typedef struct packed {
        logic valid;
        logic degen;
    } pss_ctl_t;

endpackage

// ----- design/pss_div.sv -----
module pss_div
    import pss_pkg::*;
#(
    parameter int NW = 34,
    parameter int DW = 17,
    parameter int QW = 17
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  pss_ctl_t        in_ctl,
    input  logic [NW-1:0]   num,
    input  logic [DW-1:0]   den,
    output pss_ctl_t        out_ctl,
    output logic [QW-1:0]   quo
);

    // Restoring division, one quotient bit per stage.
    // The upper numerator part is known to be below the divisor.
    pss_ctl_t        ctl_reg [QW];
    logic [DW-1:0]   rem_reg [QW];
    logic [DW-1:0]   den_reg [QW];
    logic [QW-1:0]   low_reg [QW];

    pss_ctl_t        ctl_src [QW];
    logic [DW-1:0]   rem_src [QW];
    logic [DW-1:0]   den_src [QW];
    logic [QW-1:0]   low_src [QW];

    logic [DW-1:0]   rem_next [QW];
    logic [QW-1:0]   low_next [QW];

    // Select each stage's source: the request for the first, the prior stage otherwise
    always_comb
    begin
        ctl_src[0] = in_ctl;
        rem_src[0] = DW'(num[NW-1:QW]);
        den_src[0] = den;
        low_src[0] = num[QW-1:0];
        for (int i = 1; i < QW; i++)
        begin
            ctl_src[i] = ctl_reg[i-1];
            rem_src[i] = rem_reg[i-1];
            den_src[i] = den_reg[i-1];
            low_src[i] = low_reg[i-1];
        end
    end

    // Shift in one numerator bit and subtract where the divisor fits
    always_comb
    begin
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        for (int i = 0; i < QW; i++)
        begin
            trial       = {rem_src[i], low_src[i][QW-1]};
            diff        = trial - {1'b0, den_src[i]};
            ge          = (trial >= {1'b0, den_src[i]});
            rem_next[i] = ge ? diff[DW-1:0] : trial[DW-1:0];
            low_next[i] = {low_src[i][QW-2:0], ge};
        end
    end

    // Advance the stages together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QW; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                ctl_reg[i] <= ctl_src[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QW; i++)
            begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_src[i];
                low_reg[i] <= low_next[i];
            end
        end
    end

    assign out_ctl = ctl_reg[QW-1];
    assign quo     = low_reg[QW-1];

endmodule

// ----- design/pss_sqrt.sv -----
module pss_sqrt
    import pss_pkg::*;
#(
    parameter int VW = 33,
    parameter int RW = 17
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  pss_ctl_t        in_ctl,
    input  logic [VW-1:0]   val,
    output pss_ctl_t        out_ctl,
    output logic [RW-1:0]   root
);

    localparam int PW = 2 * RW;

    // Digit-by-digit square root, one result bit per stage
    pss_ctl_t        ctl_reg  [RW];
    logic [RW:0]     rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [PW-1:0]   val_reg  [RW];

    pss_ctl_t        ctl_src  [RW];
    logic [RW:0]     rem_src  [RW];
    logic [RW-1:0]   root_src [RW];
    logic [PW-1:0]   val_src  [RW];

    logic [RW:0]     rem_next  [RW];
    logic [RW-1:0]   root_next [RW];

    // Select each stage's source
    always_comb
    begin
        ctl_src[0]  = in_ctl;
        rem_src[0]  = '0;
        root_src[0] = '0;
        val_src[0]  = PW'(val);
        for (int i = 1; i < RW; i++)
        begin
            ctl_src[i]  = ctl_reg[i-1];
            rem_src[i]  = rem_reg[i-1];
            root_src[i] = root_reg[i-1];
            val_src[i]  = val_reg[i-1];
        end
    end

    // Bring down two bits and try the next root bit
    always_comb
    begin
        logic [RW+2:0] trial;
        logic [RW+2:0] sub;
        logic [RW+2:0] diff;
        logic          ge;
        for (int i = 0; i < RW; i++)
        begin
            trial        = {rem_src[i], val_src[i][PW-1:PW-2]};
            sub          = (RW+3)'({root_src[i], 2'b01});
            diff         = trial - sub;
            ge           = (trial >= sub);
            rem_next[i]  = ge ? diff[RW:0] : trial[RW:0];
            root_next[i] = {root_src[i][RW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RW; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < RW; i++)
            begin
                ctl_reg[i] <= ctl_src[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < RW; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                val_reg[i]  <= {val_src[i][PW-3:0], 2'b00};
            end
        end
    end

    assign out_ctl = ctl_reg[RW-1];
    assign root    = root_reg[RW-1];

endmodule

// ----- design/point_segment_distance.sv -----
// Pipeline: six setup stages, 2*COORD_BITS+1 divider stages, COORD_BITS+1 square root stages.
// Throughput: one request per cycle; the whole pipeline advances on one enable,
// which holds only while a finished result is stalled at the output.
// Reset: rst_n clears all valid bits asynchronously; data registers keep no reset.
module point_segment_distance
    import pss_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COORD_BITS:0]          dist_res,
    output logic                         degenerate
);

    localparam int W  = COORD_BITS;
    localparam int P  = 2 * W + 2;      // product width
    localparam int S  = 2 * W + 3;      // sum width
    localparam int CW = 2 * W + 1;      // magnitude of cross, len2, squared distances
    localparam int H  = (CW + 1) / 2;   // split point for squaring the cross term
    localparam int NW = 2 * CW;
    localparam int RW = W + 1;

    logic en;
    pss_ctl_t div_ctl, sq_ctl;
    logic [CW-1:0] quo;

    // Stage 1: differences
    pss_ctl_t ctl1_reg;
    logic signed [W:0] abx_reg, aby_reg, apx_reg, apy_reg, bpx_reg, bpy_reg;

    // Stage 2: products
    pss_ctl_t ctl2_reg;
    logic signed [P-1:0] l0_reg, l1_reg, d0_reg, d1_reg, c0_reg, c1_reg;
    logic signed [P-1:0] a0_reg, a1_reg, b0_reg, b1_reg;

    // Stage 3: sums
    pss_ctl_t ctl3_reg;
    logic signed [S-1:0] len2_reg, dot_reg, cross_reg, da_reg, db_reg;

    // Stage 4: case selection
    pss_ctl_t ctl4_reg;
    pss_ctl_t ctl4_next;
    logic perp4_reg, perp4_next;
    logic [CW-1:0] c4_reg, c4_next, len4_reg, v4_reg, v4_next;

    // Stage 5: partial products of the cross term squared
    pss_ctl_t ctl5_reg;
    logic perp5_reg;
    logic [2*(CW-H)-1:0] hh_reg;
    logic [CW-1:0] hl_reg;
    logic [2*H-1:0] ll_reg;
    logic [CW-1:0] len5_reg, v5_reg;

    // Stage 6: dividend and divisor
    pss_ctl_t ctl6_reg;
    logic [NW-1:0] num6_reg, num6_next;
    logic [CW-1:0] den6_reg, den6_next;

    // Hold everything while a finished result waits
    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;

    // Pick the case from projection and length
    always_comb
    begin
        logic signed [S-1:0] mag;
        logic degen;
        logic dot_le0;
        logic dot_ge;
        degen     = (len2_reg == '0);
        dot_le0   = dot_reg[S-1] || (dot_reg == '0);
        dot_ge    = (dot_reg >= len2_reg);
        mag       = cross_reg[S-1] ? -cross_reg : cross_reg;
        c4_next   = mag[CW-1:0];
        perp4_next = !degen && !dot_le0 && !dot_ge;
        v4_next   = (degen || dot_le0) ? da_reg[CW-1:0] : db_reg[CW-1:0];
        ctl4_next.valid = ctl3_reg.valid;
        ctl4_next.degen = degen;
    end

    // Combine partial products; endpoint cases divide by one
    always_comb
    begin
        num6_next = (NW'(hh_reg) << (2 * H)) + (NW'(hl_reg) << (H + 1)) + NW'(ll_reg);
        den6_next = len5_reg;
        if (!perp5_reg)
        begin
            num6_next = NW'(v5_reg);
            den6_next = CW'(1);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= '{valid: in_valid, degen: 1'b0};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl4_next;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
        end
    end

    // Advance data
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abx_reg <= (W+1)'(end_x)   - (W+1)'(start_x);
            aby_reg <= (W+1)'(end_y)   - (W+1)'(start_y);
            apx_reg <= (W+1)'(point_x) - (W+1)'(start_x);
            apy_reg <= (W+1)'(point_y) - (W+1)'(start_y);
            bpx_reg <= (W+1)'(point_x) - (W+1)'(end_x);
            bpy_reg <= (W+1)'(point_y) - (W+1)'(end_y);

            l0_reg <= abx_reg * abx_reg;
            l1_reg <= aby_reg * aby_reg;
            d0_reg <= abx_reg * apx_reg;
            d1_reg <= aby_reg * apy_reg;
            c0_reg <= abx_reg * apy_reg;
            c1_reg <= aby_reg * apx_reg;
            a0_reg <= apx_reg * apx_reg;
            a1_reg <= apy_reg * apy_reg;
            b0_reg <= bpx_reg * bpx_reg;
            b1_reg <= bpy_reg * bpy_reg;

            len2_reg  <= S'(l0_reg) + S'(l1_reg);
            dot_reg   <= S'(d0_reg) + S'(d1_reg);
            cross_reg <= S'(c0_reg) - S'(c1_reg);
            da_reg    <= S'(a0_reg) + S'(a1_reg);
            db_reg    <= S'(b0_reg) + S'(b1_reg);

            perp4_reg <= perp4_next;
            c4_reg    <= c4_next;
            len4_reg  <= len2_reg[CW-1:0];
            v4_reg    <= v4_next;

            perp5_reg <= perp4_reg;
            hh_reg    <= c4_reg[CW-1:H] * c4_reg[CW-1:H];
            hl_reg    <= c4_reg[CW-1:H] * c4_reg[H-1:0];
            ll_reg    <= c4_reg[H-1:0] * c4_reg[H-1:0];
            len5_reg  <= len4_reg;
            v5_reg    <= v4_reg;

            num6_reg  <= num6_next;
            den6_reg  <= den6_next;
        end
    end

    // Squared distance: cross^2 / len2 on the interior, squared distance to the nearer endpoint otherwise
    pss_div #(
        .NW(NW),
        .DW(CW),
        .QW(CW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (ctl6_reg),
        .num     (num6_reg),
        .den     (den6_reg),
        .out_ctl (div_ctl),
        .quo     (quo)
    );

    // Truncated square root gives the distance
    pss_sqrt #(
        .VW(CW),
        .RW(RW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (div_ctl),
        .val     (quo),
        .out_ctl (sq_ctl),
        .root    (dist_res)
    );

    assign out_valid  = sq_ctl.valid;
    assign degenerate = sq_ctl.degen;

endmodule

// ----- design/point_segment_distance_checker.sv -----
module point_segment_distance_checker
    import pss_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic signed [COORD_BITS-1:0] point_x,
    input logic signed [COORD_BITS-1:0] point_y,
    input logic signed [COORD_BITS-1:0] start_x,
    input logic signed [COORD_BITS-1:0] start_y,
    input logic signed [COORD_BITS-1:0] end_x,
    input logic signed [COORD_BITS-1:0] end_y,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [COORD_BITS:0]          dist_res,
    input logic                         degenerate
);

    // Input backs up exactly when a result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dist_res) && $stable(degenerate))
        else $error("stalled result changed");

    // Reset empties the pipeline
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule

bind point_segment_distance point_segment_distance_checker #(
    .COORD_BITS(COORD_BITS)
) u_checker (.*);
